FILE: sv/bpk_pkg.sv
// Shared types, command codes and checksum arithmetic for the bit packer.
package bpk_pkg;

  typedef enum logic [2:0] {
    CMD_ADD      = 3'd0,
    CMD_FLUSH    = 3'd1,
    CMD_LRC      = 3'd2,
    CMD_FLETCHER = 3'd3,
    CMD_START    = 3'd4
  } cmd_t;

  typedef struct packed {
    logic clr;
    logic lrc;
    logic f2;
    logic f1;
  } job_ctl_t;

  localparam int CMD_W   = 3;
  localparam int NBITS_W = 6;
  localparam int BYTE_W  = 8;

  localparam logic [BYTE_W-1:0] FSUM_INIT = 8'hff;
  localparam logic [BYTE_W-1:0] XOR_INIT  = 8'h00;

  function automatic logic [BYTE_W-1:0] mod255_add(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t > {1'b0, FSUM_INIT}) begin
      t = t - {1'b0, FSUM_INIT};
    end
    return t[BYTE_W-1:0];
  endfunction

endpackage

FILE: sv/bpk_pack.sv
// Request stage: merges the partial byte with appended bits and builds the byte job.
module bpk_pack
  import bpk_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int NBYTE      = 5,
  parameter int IN_W       = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [IN_W-1:0]                    in_tdata,
  input  logic                               emit_rdy,
  output logic                               ld,
  output logic [NBYTE*BYTE_W-1:0]            ld_buf,
  output logic [$clog2(NBYTE+1)-1:0]         ld_cnt,
  output job_ctl_t                           ld_ctl
);

  localparam int BUF_W = NBYTE * BYTE_W;
  localparam int CNT_W = $clog2(NBYTE + 1);
  localparam int TOT_W = CNT_W + 3;
  localparam int NB_W  = $clog2(VALUE_BITS + 1);

  logic [BYTE_W-1:0]     partial_r, partial_nxt;
  logic [2:0]            fill_r, fill_nxt;
  logic [CMD_W-1:0]      cmd;
  logic [VALUE_BITS-1:0] value;
  logic [NBITS_W-1:0]    nbits;
  logic [NB_W-1:0]       n;
  logic [VALUE_BITS-1:0] masked;
  logic [BUF_W-1:0]      add_buf;
  logic [BUF_W-1:0]      rest;
  logic [TOT_W-1:0]      total;
  logic [CNT_W-1:0]      add_cnt;

  assign cmd   = in_tdata[CMD_W-1:0];
  assign value = in_tdata[CMD_W +: VALUE_BITS];
  assign nbits = in_tdata[CMD_W+VALUE_BITS +: NBITS_W];

  assign in_tready = emit_rdy;
  assign ld        = in_tvalid & in_tready;

  always_comb begin
    if (32'(nbits) > 32'(VALUE_BITS)) begin
      n = NB_W'(VALUE_BITS);
    end else begin
      n = NB_W'(nbits);
    end
  end

  assign masked  = value & ~({VALUE_BITS{1'b1}} << n);
  assign add_buf = BUF_W'(partial_r) | (BUF_W'(masked) << fill_r);
  assign total   = TOT_W'(fill_r) + TOT_W'(n);
  assign add_cnt = total[TOT_W-1:3];
  assign rest    = add_buf >> {add_cnt, 3'b000};

  always_comb begin
    partial_nxt = partial_r;
    fill_nxt    = fill_r;
    ld_buf      = BUF_W'(partial_r);
    ld_cnt      = CNT_W'(fill_r != 3'd0);
    ld_ctl      = '0;
    case (cmd_t'(cmd))
      CMD_ADD: begin
        ld_buf      = add_buf;
        ld_cnt      = add_cnt;
        partial_nxt = rest[BYTE_W-1:0];
        fill_nxt    = total[2:0];
      end
      CMD_FLUSH: begin
        partial_nxt = '0;
        fill_nxt    = '0;
      end
      CMD_LRC: begin
        partial_nxt = '0;
        fill_nxt    = '0;
        ld_ctl.lrc  = 1'b1;
      end
      CMD_FLETCHER: begin
        partial_nxt = '0;
        fill_nxt    = '0;
        ld_ctl.f2   = 1'b1;
        ld_ctl.f1   = 1'b1;
      end
      CMD_START: begin
        partial_nxt = '0;
        fill_nxt    = '0;
        ld_cnt      = '0;
        ld_ctl.clr  = 1'b1;
      end
      default: begin
        ld_cnt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      fill_r    <= '0;
    end else if (ld) begin
      partial_r <= partial_nxt;
      fill_r    <= fill_nxt;
    end
  end

endmodule

FILE: sv/bpk_emit.sv
// Byte emitter: drains the job one byte a cycle unless stalled; LRC/Fletcher sums; output reg.
module bpk_emit
  import bpk_pkg::*;
#(
  parameter int NBYTE = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ld,
  input  logic [NBYTE*BYTE_W-1:0]     ld_buf,
  input  logic [$clog2(NBYTE+1)-1:0]  ld_cnt,
  input  job_ctl_t                    ld_ctl,
  output logic                        emit_rdy,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [BYTE_W-1:0]           out_tdata,
  output logic                        out_tlast
);

  localparam int BUF_W = NBYTE * BYTE_W;
  localparam int CNT_W = $clog2(NBYTE + 1);

  logic [BUF_W-1:0]  buf_r, buf_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              lrc_r, lrc_nxt;
  logic              f2_r, f2_nxt;
  logic              f1_r, f1_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic [BYTE_W-1:0] s1_r, s1_nxt;
  logic [BYTE_W-1:0] s2_r, s2_nxt;
  logic [BYTE_W-1:0] hold_r;
  logic              ovalid_r;
  logic [BYTE_W-1:0] obyte_r;
  logic              olast_r;
  logic              busy;
  logic              fire;
  logic              fin;
  logic              has_data;
  logic [BYTE_W-1:0] emit_byte;
  logic [CNT_W-1:0]  a_cnt;
  logic              a_lrc, a_f2, a_f1;

  assign has_data = (cnt_r != '0);
  assign busy     = has_data | lrc_r | f2_r | f1_r;
  assign fire     = busy & (!ovalid_r | out_tready);

  always_comb begin
    a_cnt = cnt_r;
    a_lrc = lrc_r;
    a_f2  = f2_r;
    a_f1  = f1_r;
    if (has_data) begin
      emit_byte = buf_r[BYTE_W-1:0];
      a_cnt     = cnt_r - CNT_W'(1);
    end else if (lrc_r) begin
      emit_byte = xor_r;
      a_lrc     = 1'b0;
    end else if (f2_r) begin
      emit_byte = s2_r;
      a_f2      = 1'b0;
    end else begin
      emit_byte = hold_r;
      a_f1      = 1'b0;
    end
  end

  assign fin      = (a_cnt == '0) & !a_lrc & !a_f2 & !a_f1;
  assign emit_rdy = !busy | (fire & fin);

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    lrc_nxt = lrc_r;
    f2_nxt  = f2_r;
    f1_nxt  = f1_r;
    xor_nxt = xor_r;
    s1_nxt  = s1_r;
    s2_nxt  = s2_r;
    if (fire) begin
      buf_nxt = buf_r >> BYTE_W;
      cnt_nxt = a_cnt;
      lrc_nxt = a_lrc;
      f2_nxt  = a_f2;
      f1_nxt  = a_f1;
      xor_nxt = xor_r ^ emit_byte;
      s1_nxt  = mod255_add(s1_r, emit_byte);
      s2_nxt  = mod255_add(s2_r, s1_nxt);
    end
    if (ld) begin
      buf_nxt = ld_buf;
      cnt_nxt = ld_cnt;
      lrc_nxt = ld_ctl.lrc;
      f2_nxt  = ld_ctl.f2;
      f1_nxt  = ld_ctl.f1;
      if (ld_ctl.clr) begin
        xor_nxt = XOR_INIT;
        s1_nxt  = FSUM_INIT;
        s2_nxt  = FSUM_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (fire && !has_data && !lrc_r && f2_r) begin
      hold_r <= s1_r;
    end
    if (fire) begin
      obyte_r <= emit_byte;
      olast_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      lrc_r    <= 1'b0;
      f2_r     <= 1'b0;
      f1_r     <= 1'b0;
      xor_r    <= XOR_INIT;
      s1_r     <= FSUM_INIT;
      s2_r     <= FSUM_INIT;
      ovalid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      lrc_r <= lrc_nxt;
      f2_r  <= f2_nxt;
      f1_r  <= f1_nxt;
      xor_r <= xor_nxt;
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      if (fire) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ld |-> (!busy || (fire && fin)))
    else $error("job loaded over pending bytes");

  a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> ovalid_r)
    else $error("emitted byte not presented");

  a_f2_before_f1: assert property (@(posedge clk) disable iff (!rst_n)
    f2_r |-> f1_r)
    else $error("fletcher sum2 pending without sum1");

  a_check_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !(lrc_r && f2_r))
    else $error("lrc and fletcher both pending");

endmodule

FILE: sv/lsb_first_bit_packer_with_checksums.sv
// Top level: LSB-first bit packer with LRC and Fletcher-16 check bytes.
// A request's bytes go from the emitter's job registers through the one output register to out_*.
// A new request is accepted as the last byte of the previous one fires; one with no bytes
// adds no wait. Bytes drain one per cycle through the emitter, unless out_tready stalls them.
// Reset (rst_n low, synchronous): partial byte empty, LRC 0, both Fletcher sums 255.
module lsb_first_bit_packer_with_checksums
  import bpk_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             in_tvalid,
  output logic                                             in_tready,
  // cmd[2:0], value[VALUE_BITS+2:3], nbits[VALUE_BITS+8:VALUE_BITS+3], zero fill
  input  logic [((CMD_W+VALUE_BITS+NBITS_W+7)/8)*8-1:0]   in_tdata,
  output logic                                             out_tvalid,
  input  logic                                             out_tready,
  // out_byte[7:0]
  output logic [BYTE_W-1:0]                                out_tdata,
  output logic                                             out_tlast
);

  localparam int IN_W  = ((CMD_W + VALUE_BITS + NBITS_W + 7) / 8) * 8;
  localparam int NBYTE = (VALUE_BITS + 14) / 8;
  localparam int CNT_W = $clog2(NBYTE + 1);

  logic                    emit_rdy;
  logic                    ld;
  logic [NBYTE*BYTE_W-1:0] ld_buf;
  logic [CNT_W-1:0]        ld_cnt;
  job_ctl_t                ld_ctl;

  bpk_pack #(
    .VALUE_BITS (VALUE_BITS),
    .NBYTE      (NBYTE),
    .IN_W       (IN_W)
  ) u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .emit_rdy  (emit_rdy),
    .ld        (ld),
    .ld_buf    (ld_buf),
    .ld_cnt    (ld_cnt),
    .ld_ctl    (ld_ctl)
  );

  bpk_emit #(
    .NBYTE (NBYTE)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (ld),
    .ld_buf     (ld_buf),
    .ld_cnt     (ld_cnt),
    .ld_ctl     (ld_ctl),
    .emit_rdy   (emit_rdy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
